### design/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg
// Shared types and defaults for the online covariance / correlation block.
// ----------------------------------------------------------------------------
package occ_pkg;

  localparam int SAMPLE_WIDTH_DEF         = 32;
  localparam int SAMPLE_FRACTION_BITS_DEF = 16;
  localparam int COUNT_WIDTH_DEF          = 32;

  // One input pair as it travels from the front to the back.
  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        kept;
    logic        last;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] value;
    logic        defined;
    logic [31:0] used;
  } result_t;

  // Divider request: num is left aligned, the top 64 or 128 bits are used.
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
    logic         long_div;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

### design/online_covariance_correlation_top.sv
// ----------------------------------------------------------------------------
// online_covariance_correlation_top
// Streaming Welford covariance / Pearson correlation over groups of pairs.
// ----------------------------------------------------------------------------
// Pairs enter through a two-entry input queue; pairs with a missing sample
// and no group end are dropped there while it is not full. Each kept pair
// runs in the back through two passes of the shared bit-serial divider for
// the mean updates, then three multiplies for the co-moment and variances.
// A group end gives one result: covariance uses one division, correlation
// a multiply, a square root and a 128-bit division. Results wait in a
// two-entry output queue, so the back keeps working until it is full.
// mode_select is captured on cfg_valid; the captured mode is used when a
// group end is processed.
// ----------------------------------------------------------------------------
module online_covariance_correlation_top #(
  parameter int SAMPLE_WIDTH         = occ_pkg::SAMPLE_WIDTH_DEF,
  parameter int SAMPLE_FRACTION_BITS = occ_pkg::SAMPLE_FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH          = occ_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] sample_x,
  input  logic [31:0] sample_y,
  input  logic        x_present,
  input  logic        y_present,
  input  logic        group_end,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] stat_value,
  output logic        stat_defined,
  output logic [31:0] pairs_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        mode_select
);
  import occ_pkg::*;

  logic    mode;
  logic    item_valid;
  item_t   item;
  logic    item_ready;
  logic    outq_full;
  logic    res_push;
  result_t res;
  result_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= mode_select;
    end
  end

  occ_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .x_present  (x_present),
    .y_present  (y_present),
    .group_end  (group_end),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  occ_back #(
    .SAMPLE_WIDTH         (SAMPLE_WIDTH),
    .SAMPLE_FRACTION_BITS (SAMPLE_FRACTION_BITS),
    .COUNT_WIDTH          (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .outq_full  (outq_full),
    .res_push   (res_push),
    .res        (res)
  );

  occ_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .full  (outq_full),
    .empty (empty),
    .pop   (pop),
    .rdata (head)
  );

  assign stat_value   = head.value;
  assign stat_defined = head.defined;
  assign pairs_used   = head.used;

endmodule

### design/occ_front.sv
// ----------------------------------------------------------------------------
// occ_front
// Input side: accepts pairs, drops pairs with no work, queues the rest.
// ----------------------------------------------------------------------------
module occ_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [31:0]   sample_x,
  input  logic [31:0]   sample_y,
  input  logic          x_present,
  input  logic          y_present,
  input  logic          group_end,
  output logic          item_valid,
  output occ_pkg::item_t item,
  input  logic          item_ready
);
  import occ_pkg::*;

  item_t       mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        kept;
  logic        store;
  logic        take;

  assign kept       = x_present & y_present;
  assign full       = (count == 2'd2);
  // a pair with a missing sample and no group end changes nothing
  assign store      = push & ~full & (kept | group_end);
  assign item_valid = (count != 2'd0);
  assign item       = mem[rptr];
  assign take       = item_valid & item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (store) begin
        wptr <= ~wptr;
      end
      if (take) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, store} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[wptr] <= '{sx: sample_x, sy: sample_y, kept: kept, last: group_end};
    end
  end

endmodule

### design/occ_div.sv
// ----------------------------------------------------------------------------
// occ_div
// Radix-2 restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module occ_div (
  input  logic              clk,
  input  logic              rst,
  input  occ_pkg::div_req_t req,
  output occ_pkg::div_rsp_t rsp
);
  import occ_pkg::*;

  logic         busy;
  logic         done;
  logic [6:0]   cnt;
  logic [127:0] num_sh;
  logic [63:0]  rem;
  logic [63:0]  den;
  logic [127:0] quo;
  logic [64:0]  rem_sh;
  logic         qbit;
  logic [63:0]  rem_next;

  assign rem_sh   = {rem, num_sh[127]};
  assign qbit     = (rem_sh >= {1'b0, den});
  assign rem_next = qbit ? 64'(rem_sh - {1'b0, den}) : rem_sh[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        num_sh <= req.num;
        rem    <= '0;
        quo    <= '0;
        den    <= req.den;
        cnt    <= req.long_div ? 7'd127 : 7'd63;
      end else if (busy) begin
        num_sh <= {num_sh[126:0], 1'b0};
        rem    <= rem_next;
        quo    <= {quo[126:0], qbit};
        cnt    <= cnt - 7'd1;
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = (|quo[127:64]) ? '1 : quo[63:0];

endmodule

### design/occ_back.sv
// ----------------------------------------------------------------------------
// occ_back
// Welford update sequencer and end-of-group statistic.
// ----------------------------------------------------------------------------
module occ_back #(
  parameter int SAMPLE_WIDTH         = occ_pkg::SAMPLE_WIDTH_DEF,
  parameter int SAMPLE_FRACTION_BITS = occ_pkg::SAMPLE_FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH          = occ_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             mode,
  input  logic             item_valid,
  input  occ_pkg::item_t   item,
  output logic             item_ready,
  input  logic             outq_full,
  output logic             res_push,
  output occ_pkg::result_t res
);
  import occ_pkg::*;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam int          SHIFT   = 32 - SAMPLE_FRACTION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DSTART, S_DWAIT, S_TMP, S_MUL, S_MACC, S_END,
    S_SQINIT, S_SQRT, S_OUT
  } state_t;

  typedef enum logic [1:0] {D_MX, D_MY, D_COV, D_COR} div_sel_t;
  typedef enum logic [1:0] {M_CM, M_VX, M_VY, M_PROD} mul_sel_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [31:0] out32(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    logic [63:0] c;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    c   = (m > lim) ? lim : m;
    return neg ? (32'd0 - c[31:0]) : c[31:0];
  endfunction

  function automatic logic [63:0] q32(input logic neg, input logic [127:0] p);
    logic [63:0] lim;
    logic [63:0] lo;
    lim = neg ? S64_MIN : S64_MAX;
    lo  = p[95:32];
    if ((p[127:96] != 32'd0) || (lo > lim)) lo = lim;
    return neg ? (64'd0 - lo) : lo;
  endfunction

  function automatic logic [63:0] to_q32(input logic [31:0] raw);
    logic [63:0] v;
    v = 64'($signed(raw[SAMPLE_WIDTH-1:0]));
    return v << SHIFT;
  endfunction

  state_t                 state;
  div_sel_t               div_sel;
  mul_sel_t               mul_sel;
  logic                   last;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [63:0]            mean_x, mean_y, comoment, var_x, var_y;
  logic [63:0]            sx, sy, dx, dy, tx, ty;
  logic [63:0]            sx_in, sy_in;
  logic [2:0]             mcnt;
  logic [1:0]             psh;
  logic [63:0]            pp;
  logic [127:0]           acc;
  logic [63:0]            opa, opb, ma, mb;
  logic                   mneg;
  logic [31:0]            pa, pb;
  logic [63:0]            pprod;
  logic [6:0]             shamt;
  logic [127:0]           sq_n;
  logic [67:0]            sq_rem;
  logic [63:0]            root;
  logic [5:0]             scnt;
  logic [67:0]            sq_sh, sq_trial;
  logic [31:0]            value;
  logic                   defined;
  logic [63:0]            qsig;
  logic [63:0]            mq;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  occ_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item_ready = (state == S_IDLE);
  assign res_push   = (state == S_OUT) && !outq_full;
  assign res        = '{value: value, defined: defined, used: 32'(count)};
  assign count_next = (count == '1) ? count : count + 1'b1;
  assign sx_in      = to_q32(item.sx);
  assign sy_in      = to_q32(item.sy);

  always_comb begin
    div_req.start    = (state == S_DSTART);
    div_req.long_div = 1'b0;
    div_req.den      = 64'(count);
    case (div_sel)
      D_MX:    div_req.num = {mag64(dx), 64'd0};
      D_MY:    div_req.num = {mag64(dy), 64'd0};
      D_COV: begin
        div_req.num = {mag64(comoment), 64'd0};
        div_req.den = 64'(count - 1'b1);
      end
      default: begin
        div_req.num      = {64'd0, mag64(comoment)} << 30;
        div_req.den      = root;
        div_req.long_div = 1'b1;
      end
    endcase
  end

  // mean step: quotient of |delta| / n with the sign of delta
  assign qsig = (((div_sel == D_MX) ? dx[63] : dy[63])) ? (64'd0 - div_rsp.quo)
                                                         : div_rsp.quo;

  always_comb begin
    case (mul_sel)
      M_CM:    begin opa = tx;    opb = dy;    end
      M_VX:    begin opa = tx;    opb = dx;    end
      M_VY:    begin opa = ty;    opb = dy;    end
      default: begin opa = var_x; opb = var_y; end
    endcase
    ma   = mag64(opa);
    mb   = mag64(opb);
    mneg = opa[63] ^ opb[63];
    case (mcnt[1:0])
      2'd0:    begin pa = ma[31:0];  pb = mb[31:0];  end
      2'd1:    begin pa = ma[31:0];  pb = mb[63:32]; end
      2'd2:    begin pa = ma[63:32]; pb = mb[31:0];  end
      default: begin pa = ma[63:32]; pb = mb[63:32]; end
    endcase
    case (psh)
      2'd0:    shamt = 7'd0;
      2'd3:    shamt = 7'd64;
      default: shamt = 7'd32;
    endcase
  end

  assign pprod    = pa * pb;
  assign mq       = q32(mneg, acc);
  assign sq_sh    = {sq_rem[65:0], sq_n[127:126]};
  assign sq_trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      div_sel  <= D_MX;
      mul_sel  <= M_CM;
      last     <= 1'b0;
      count    <= '0;
      mean_x   <= '0;
      mean_y   <= '0;
      comoment <= '0;
      var_x    <= '0;
      var_y    <= '0;
      mcnt     <= '0;
      scnt     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            last <= item.last;
            if (item.kept) begin
              count   <= count_next;
              sx      <= sx_in;
              sy      <= sy_in;
              dx      <= sat_sub(sx_in, mean_x);
              dy      <= sat_sub(sy_in, mean_y);
              div_sel <= D_MX;
              state   <= S_DSTART;
            end else if (item.last) begin
              state <= S_END;
            end
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            case (div_sel)
              D_MX: begin
                mean_x  <= sat_add(mean_x, qsig);
                div_sel <= D_MY;
                state   <= S_DSTART;
              end
              D_MY: begin
                mean_y <= sat_add(mean_y, qsig);
                state  <= S_TMP;
              end
              D_COV: begin
                value   <= out32(comoment[63], div_rsp.quo >> 16);
                defined <= 1'b1;
                state   <= S_OUT;
              end
              default: begin
                value   <= out32(comoment[63], div_rsp.quo);
                defined <= 1'b1;
                state   <= S_OUT;
              end
            endcase
          end
        end
        S_TMP: begin
          tx      <= sat_sub(sx, mean_x);
          ty      <= sat_sub(sy, mean_y);
          mul_sel <= M_CM;
          mcnt    <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          // one 32x32 partial product a cycle, added in the cycle after
          pp   <= pprod;
          psh  <= mcnt[1:0];
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd0) begin
            acc <= '0;
          end else begin
            acc <= acc + ({64'd0, pp} << shamt);
          end
          if (mcnt == 3'd4) begin
            state <= (mul_sel == M_PROD) ? S_SQINIT : S_MACC;
          end
        end
        S_MACC: begin
          mcnt <= '0;
          case (mul_sel)
            M_CM: begin
              comoment <= sat_add(comoment, mq);
              mul_sel  <= M_VX;
              state    <= S_MUL;
            end
            M_VX: begin
              var_x   <= sat_add(var_x, mq);
              mul_sel <= M_VY;
              state   <= S_MUL;
            end
            default: begin
              var_y <= sat_add(var_y, mq);
              state <= last ? S_END : S_IDLE;
            end
          endcase
        end
        S_END: begin
          value   <= '0;
          defined <= 1'b0;
          state   <= S_OUT;
          if (count > 1) begin
            if (!mode) begin
              div_sel <= D_COV;
              state   <= S_DSTART;
            end else if (!var_x[63] && (var_x != 64'd0) &&
                         !var_y[63] && (var_y != 64'd0)) begin
              mul_sel <= M_PROD;
              mcnt    <= '0;
              state   <= S_MUL;
            end
          end
        end
        S_SQINIT: begin
          sq_n   <= acc;
          sq_rem <= '0;
          root   <= '0;
          scnt   <= 6'd63;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          // two radicand bits per step, one root bit
          sq_n <= {sq_n[125:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            sq_rem <= sq_sh - sq_trial;
            root   <= {root[62:0], 1'b1};
          end else begin
            sq_rem <= sq_sh;
            root   <= {root[62:0], 1'b0};
          end
          scnt <= scnt - 6'd1;
          if (scnt == 6'd0) begin
            div_sel <= D_COR;
            state   <= S_DSTART;
          end
        end
        S_OUT: begin
          if (!outq_full) begin
            count    <= '0;
            mean_x   <= '0;
            mean_y   <= '0;
            comoment <= '0;
            var_x    <= '0;
            var_y    <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (count == '0) && (comoment == 64'd0) && (mean_x == 64'd0))
    else $error("group state not cleared after result");

  a_front_classify: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !item.kept |-> item.last)
    else $error("pair with no work reached the back");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DWAIT)
    else $error("divider result outside wait state");
`endif

endmodule

### design/occ_outq.sv
// ----------------------------------------------------------------------------
// occ_outq
// Two-entry result queue between the back and the result port.
// ----------------------------------------------------------------------------
module occ_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  occ_pkg::result_t wdata,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output occ_pkg::result_t rdata
);
  import occ_pkg::*;

  result_t    mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       put;
  logic       take;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign put   = wr & ~full;
  assign take  = pop & ~empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (put) begin
        wptr <= ~wptr;
      end
      if (take) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, put} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
